### hdl/pnn_pkg.sv
`timescale 1ns / 1ps

package pnn_pkg;

    localparam int COORD_W  = 24;               // Q12.12 vertex coordinate
    localparam int BIAS_W   = 12;
    localparam int PROD_W   = 2 * (COORD_W + 1); // one Newell term
    localparam int SUM_W    = 58;               // saturating running sum
    localparam int MAG_W    = SUM_W;            // magnitude of a sum
    localparam int A_W      = 30;               // normalised magnitude
    localparam int SQ_W     = 2 * A_W;
    localparam int ROOT_W   = 64;               // radicand and root working width
    localparam int R_W      = 31;               // final root
    localparam int FRAC_SH  = 15;               // Q1.15 scaling
    localparam int NUM_W    = A_W + FRAC_SH + 1;
    localparam int QUO_W    = 16;
    localparam int OUT_W    = 16;
    localparam int CNT_W    = 5;
    localparam int COMP_W   = 2;
    localparam int SQ_CYCLES = 4;               // three squares plus the last accumulate
    localparam int DIV_STEPS = QUO_W;

    localparam logic signed [OUT_W-1:0] ONE_Q15 = 16'sd32767;
    localparam logic [COMP_W-1:0] LAST_COMP = 2'd2;
    localparam logic [COMP_W-1:0] ALL_COMPS = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_CLOSE_MUL,
        ST_CLOSE_ADD,
        ST_ABS,
        ST_MAX,
        ST_SHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_OUT
    } pnn_state_t;

    typedef struct packed {
        logic              load_first;
        logic              load_pair;
        logic              close_pair;
        logic              add_sums;
        logic              upd_prev;
        logic              abs_load;
        logic              max_load;
        logic              shift_step;
        logic              sq_load;
        logic              q_acc;
        logic              rt_step;
        logic              div_init;
        logic              div_step;
        logic              div_end;
        logic              out_load;
        logic [COMP_W-1:0] comp;
    } pnn_cmd_t;

    typedef struct packed {
        logic m_zero;
        logic m_in_range;
        logic rt_last;
    } pnn_sts_t;

endpackage

### hdl/pnn_datapath.sv
`timescale 1ns / 1ps

module pnn_datapath import pnn_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [BIAS_W-1:0]         cfg_wr_data,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    input  logic signed [COORD_W-1:0] s_coord_z,
    input  pnn_cmd_t                  cmd,
    output pnn_sts_t                  sts,
    output logic signed [OUT_W-1:0]   m_normal_x,
    output logic signed [OUT_W-1:0]   m_normal_y,
    output logic signed [OUT_W-1:0]   m_normal_z,
    output logic                      m_degenerate
);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    function automatic logic signed [COORD_W-1:0] bias_sat(
        input logic signed [COORD_W-1:0] c,
        input logic [BIAS_W-1:0]         b
    );
        logic signed [COORD_W:0] t;
        t = {c[COORD_W-1], c} + {{(COORD_W+1-BIAS_W){1'b0}}, b};
        // The bias is never negative, so only the upper bound can be crossed.
        if (!t[COORD_W] && t[COORD_W-1]) begin
            return COORD_MAX;
        end
        return t[COORD_W-1:0];
    endfunction

    function automatic logic signed [PROD_W-1:0] term(
        input logic signed [COORD_W-1:0] ad,
        input logic signed [COORD_W-1:0] bd,
        input logic signed [COORD_W-1:0] as,
        input logic signed [COORD_W-1:0] bs
    );
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] s;
        d = {ad[COORD_W-1], ad} - {bd[COORD_W-1], bd};
        s = {as[COORD_W-1], as} + {bs[COORD_W-1], bs};
        return d * s;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  acc,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [SUM_W:0] t;
        t = {acc[SUM_W-1], acc} + {{(SUM_W+1-PROD_W){p[PROD_W-1]}}, p};
        if (t[SUM_W] != t[SUM_W-1]) begin
            return t[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return t[SUM_W-1:0];
    endfunction

    logic [BIAS_W-1:0]         bias_reg;
    logic signed [COORD_W-1:0] in_vec   [3];
    logic signed [COORD_W-1:0] biased   [3];
    logic signed [COORD_W-1:0] b_vec    [3];
    logic signed [COORD_W-1:0] first_reg[3];
    logic signed [COORD_W-1:0] prev_reg [3];
    logic signed [COORD_W-1:0] cur_reg  [3];
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [PROD_W-1:0]  prod_next[3];
    logic signed [SUM_W-1:0]   sums_reg [3];
    logic [MAG_W-1:0]          mag_reg  [3];
    logic                      neg_reg  [3];
    logic [MAG_W-1:0]          m_reg;
    logic [MAG_W-1:0]          m_next;
    logic [A_W-1:0]            a_sel;
    logic [SQ_W-1:0]           sq_reg;
    logic [ROOT_W-1:0]         rt_q_reg;
    logic [ROOT_W-1:0]         rt_res_reg;
    logic [ROOT_W-1:0]         rt_bit_reg;
    logic [ROOT_W-1:0]         rt_trial;
    logic [R_W-1:0]            root;
    logic [NUM_W-1:0]          num;
    logic [R_W-1:0]            div_rem_reg;
    logic [QUO_W-1:0]          div_num_reg;
    logic [QUO_W-1:0]          div_quo_reg;
    logic [R_W:0]              div_trial;
    logic                      div_ge;
    logic [QUO_W-1:0]          quo_sat;
    logic signed [OUT_W-1:0]   nrm_reg  [3];
    logic signed [OUT_W-1:0]   nrm_next;
    logic                      shift_right;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0;
        end else if (cfg_wr_en) begin
            bias_reg <= cfg_wr_data;
        end
    end

    assign in_vec[0] = s_coord_x;
    assign in_vec[1] = s_coord_y;
    assign in_vec[2] = s_coord_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            biased[i] = bias_sat(in_vec[i], bias_reg);
            b_vec[i]  = cmd.close_pair ? first_reg[i] : in_vec[i];
        end
        prod_next[0] = term(prev_reg[1], b_vec[1], prev_reg[2], b_vec[2]);
        prod_next[1] = term(prev_reg[2], b_vec[2], prev_reg[0], b_vec[0]);
        prod_next[2] = term(prev_reg[0], b_vec[0], prev_reg[1], b_vec[1]);
    end

    // Vertex storage and Newell accumulation.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (cmd.load_first) begin
                first_reg[i] <= biased[i];
                prev_reg[i]  <= biased[i];
                sums_reg[i]  <= '0;
            end else begin
                if (cmd.upd_prev) begin
                    prev_reg[i] <= cur_reg[i];
                end
                if (cmd.add_sums) begin
                    sums_reg[i] <= sat_add(sums_reg[i], prod_reg[i]);
                end
            end
            if (cmd.load_pair) begin
                cur_reg[i] <= in_vec[i];
            end
            if (cmd.load_pair || cmd.close_pair) begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    always_comb begin
        m_next = mag_reg[0];
        if (mag_reg[1] > m_next) begin
            m_next = mag_reg[1];
        end
        if (mag_reg[2] > m_next) begin
            m_next = mag_reg[2];
        end
    end

    // Right shifts truncate one bit at a time, which matches a single wide shift.
    assign shift_right = (m_reg[MAG_W-1:A_W] != '0);

    always_ff @(posedge aclk) begin
        if (cmd.abs_load) begin
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= sums_reg[i][SUM_W-1];
                mag_reg[i] <= sums_reg[i][SUM_W-1] ? (~sums_reg[i] + 1'b1) : sums_reg[i];
            end
        end else if (cmd.shift_step) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= shift_right ? (mag_reg[i] >> 1) : (mag_reg[i] << 1);
            end
        end
        if (cmd.max_load) begin
            m_reg <= m_next;
        end else if (cmd.shift_step) begin
            m_reg <= shift_right ? (m_reg >> 1) : (m_reg << 1);
        end
    end

    always_comb begin
        case (cmd.comp)
            2'd0:    a_sel = mag_reg[0][A_W-1:0];
            2'd1:    a_sel = mag_reg[1][A_W-1:0];
            2'd2:    a_sel = mag_reg[2][A_W-1:0];
            default: a_sel = '0;
        endcase
    end

    // Sum of squares, then a bit-pair integer square root.
    assign rt_trial = rt_res_reg + rt_bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sq_load) begin
            sq_reg <= a_sel * a_sel;
        end
        if (cmd.max_load) begin
            rt_q_reg   <= '0;
            rt_res_reg <= '0;
            rt_bit_reg <= ROOT_W'(1) << (ROOT_W - 2);
        end else if (cmd.q_acc) begin
            rt_q_reg <= rt_q_reg + ROOT_W'(sq_reg);
        end else if (cmd.rt_step) begin
            if (rt_q_reg >= rt_trial) begin
                rt_q_reg   <= rt_q_reg - rt_trial;
                rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
            end else begin
                rt_res_reg <= rt_res_reg >> 1;
            end
            rt_bit_reg <= rt_bit_reg >> 2;
        end
    end

    assign root = rt_res_reg[R_W-1:0];

    // Restoring division of (a * 2^15 + r/2) by r, one quotient bit a cycle.
    assign num       = {a_sel, {FRAC_SH{1'b0}}} + NUM_W'(root[R_W-1:1]);
    assign div_trial = {div_rem_reg, div_num_reg[QUO_W-1]};
    assign div_ge    = (div_trial >= {1'b0, root});
    assign quo_sat   = (div_quo_reg > QUO_W'(ONE_Q15)) ? QUO_W'(ONE_Q15) : div_quo_reg;

    always_comb begin
        nrm_next = quo_sat;
        case (cmd.comp)
            2'd0:    nrm_next = neg_reg[0] ? -quo_sat : quo_sat;
            2'd1:    nrm_next = neg_reg[1] ? -quo_sat : quo_sat;
            2'd2:    nrm_next = neg_reg[2] ? -quo_sat : quo_sat;
            default: nrm_next = quo_sat;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            div_rem_reg <= R_W'(num[NUM_W-1:QUO_W]);
            div_num_reg <= num[QUO_W-1:0];
            div_quo_reg <= '0;
        end else if (cmd.div_step) begin
            div_rem_reg <= div_ge ? R_W'(div_trial - {1'b0, root}) : div_trial[R_W-1:0];
            div_num_reg <= div_num_reg << 1;
            div_quo_reg <= {div_quo_reg[QUO_W-2:0], div_ge};
        end
        if (cmd.div_end) begin
            for (int i = 0; i < 3; i++) begin
                if (cmd.comp == COMP_W'(i)) begin
                    nrm_reg[i] <= nrm_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (sts.m_zero) begin
                m_normal_x   <= '0;
                m_normal_y   <= '0;
                m_normal_z   <= ONE_Q15;
                m_degenerate <= 1'b1;
            end else begin
                m_normal_x   <= nrm_reg[0];
                m_normal_y   <= nrm_reg[1];
                m_normal_z   <= nrm_reg[2];
                m_degenerate <= 1'b0;
            end
        end
    end

    assign sts.m_zero     = (m_reg == '0);
    assign sts.m_in_range = (m_reg[MAG_W-1:A_W] == '0) && m_reg[A_W-1];
    assign sts.rt_last    = rt_bit_reg[0];

`ifndef SYNTH
    // The partial remainder must stay below the root, or a quotient bit is lost.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (div_rem_reg < root))
        else $error("division remainder not below the root");

    // Each normalised magnitude is bounded by the root of the sum of squares.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_init |-> ({1'b0, a_sel} <= root))
        else $error("component magnitude exceeds the root");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rt_step |-> $onehot(rt_bit_reg))
        else $error("square root stepped without a live bit");
`endif

endmodule

### hdl/pnn_ctrl.sv
`timescale 1ns / 1ps

module pnn_ctrl import pnn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_last_vertex,
    output logic     m_valid,
    input  logic     m_ready,
    input  pnn_sts_t sts,
    output pnn_cmd_t cmd
);

    pnn_state_t        state_reg;
    pnn_state_t        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [COMP_W-1:0] comp_reg;
    logic [COMP_W-1:0] comp_next;
    logic              first_pend_reg;
    logic              first_pend_next;
    logic              last_reg;
    logic              last_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              accept;
    logic              out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!first_pend_reg) begin
                        state_next = ST_ADD;
                    end else if (s_last_vertex) begin
                        state_next = ST_CLOSE_MUL;
                    end
                end
            end
            ST_ADD:       state_next = last_reg ? ST_CLOSE_MUL : ST_IDLE;
            ST_CLOSE_MUL: state_next = ST_CLOSE_ADD;
            ST_CLOSE_ADD: state_next = ST_ABS;
            ST_ABS:       state_next = ST_MAX;
            ST_MAX:       state_next = ST_SHIFT;
            ST_SHIFT: begin
                if (sts.m_zero) begin
                    state_next = ST_OUT;
                end else if (sts.m_in_range) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (cnt_reg == CNT_W'(SQ_CYCLES - 1)) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sts.rt_last) begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: state_next = ST_DIV_STEP;
            ST_DIV_STEP: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: state_next = (comp_reg == LAST_COMP) ? ST_OUT : ST_DIV_INIT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.comp = comp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_first = accept && first_pend_reg;
                cmd.load_pair  = accept && !first_pend_reg;
            end
            ST_ADD: begin
                cmd.add_sums = 1'b1;
                cmd.upd_prev = 1'b1;
            end
            ST_CLOSE_MUL: cmd.close_pair = 1'b1;
            ST_CLOSE_ADD: cmd.add_sums   = 1'b1;
            ST_ABS:       cmd.abs_load   = 1'b1;
            ST_MAX:       cmd.max_load   = 1'b1;
            ST_SHIFT:     cmd.shift_step = !sts.m_zero && !sts.m_in_range;
            ST_SQUARE: begin
                cmd.comp    = cnt_reg[COMP_W-1:0];
                cmd.sq_load = (cnt_reg != CNT_W'(SQ_CYCLES - 1));
                cmd.q_acc   = (cnt_reg != '0);
            end
            ST_SQRT:      cmd.rt_step  = 1'b1;
            ST_DIV_INIT:  cmd.div_init = 1'b1;
            ST_DIV_STEP:  cmd.div_step = 1'b1;
            ST_DIV_END:   cmd.div_end  = 1'b1;
            ST_OUT:       cmd.out_load = out_free;
            default:      cmd.comp     = comp_reg;
        endcase
    end

    always_comb begin
        cnt_next        = '0;
        comp_next       = comp_reg;
        first_pend_next = first_pend_reg;
        last_next       = last_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        if ((state_reg == ST_SQUARE) || (state_reg == ST_DIV_STEP)) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (state_reg == ST_ABS) begin
            comp_next = '0;
        end else if (state_reg == ST_DIV_END) begin
            comp_next = comp_reg + 1'b1;
        end
        if (accept) begin
            first_pend_next = 1'b0;
            last_next       = s_last_vertex;
        end
        if (cmd.out_load) begin
            first_pend_next = 1'b1;
            m_valid_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            comp_reg       <= '0;
            first_pend_reg <= 1'b1;
            last_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            comp_reg       <= comp_next;
            first_pend_reg <= first_pend_next;
            last_reg       <= last_next;
            m_valid_reg    <= m_valid_next;
        end
    end

`ifndef SYNTH
    // The square stage may only run once the largest magnitude is normalised.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQUARE) |-> sts.m_in_range)
        else $error("squaring started before normalisation finished");

    // A proper normal is only delivered after all three divisions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !sts.m_zero) |-> (comp_reg == ALL_COMPS))
        else $error("result issued with components missing");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output state");
`endif

endmodule

### hdl/polygon_normal_newell_core.sv
`timescale 1ns / 1ps

// Unit polygon normal by Newell's method.
// Input channel (s_*): one vertex per request, signed Q12.12 coordinates, with
// s_last_vertex marking the end of a polygon. The first vertex of each polygon
// has cfg_wr_data (written with cfg_wr_en, Q0.12, reset 0) added to each axis.
// Output channel (m_*): one request per polygon, a signed Q1.15 unit normal; a
// zero Newell sum gives (0, 0, 32767) with m_degenerate set.
// The first vertex of a polygon is taken on its own; each later vertex is
// taken with its three products and then accumulated with saturation.
// After the last vertex the core accumulates, closes the loop, takes the
// magnitudes and finds the largest (no accumulate for a one-vertex polygon),
// normalises with one-bit shifts, sums the squares, takes the bit-pair square
// root, runs the three serial divisions and loads the output. A zero sum
// goes to the output after the first shift check.
// While a normal is being worked out no vertex is taken. A finished normal is
// held in the output register until m_ready; the next polygon's vertices are
// taken meanwhile, and only its own result waits for the register to free.
// Reset (aresetn low, synchronous) clears the bias, drops m_valid and makes
// the next vertex the first of a polygon.

module polygon_normal_newell_core import pnn_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [BIAS_W-1:0]         cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    input  logic signed [COORD_W-1:0] s_coord_z,
    input  logic                      s_last_vertex,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OUT_W-1:0]   m_normal_x,
    output logic signed [OUT_W-1:0]   m_normal_y,
    output logic signed [OUT_W-1:0]   m_normal_z,
    output logic                      m_degenerate
);

    pnn_cmd_t cmd;
    pnn_sts_t sts;

    pnn_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_last_vertex (s_last_vertex),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    pnn_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_coord_x    (s_coord_x),
        .s_coord_y    (s_coord_y),
        .s_coord_z    (s_coord_z),
        .cmd          (cmd),
        .sts          (sts),
        .m_normal_x   (m_normal_x),
        .m_normal_y   (m_normal_y),
        .m_normal_z   (m_normal_z),
        .m_degenerate (m_degenerate)
    );

endmodule
